>>> sv/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants for the raycaster column setup pipeline.
// ----------------------------------------------------------------------------
package rcs_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int DIST_W  = 24;
	localparam int DIR_W   = 21;
	localparam int POS_W   = 24;
	localparam int SCR_W   = 11;
	localparam int TEX_W   = 9;
	localparam int SLICE_W = 16;
	localparam int COL_W   = 8;
	localparam int SEL_W   = 2;
	localparam int STEP_W  = 24;
	localparam int OFS_W   = 15;
	localparam int START_W = 40;

	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 112;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = SCR_W'(480);
	localparam logic [TEX_W-1:0] TEXTURE_SIZE_RST  = TEX_W'(64);
	localparam logic [TEX_W-1:0] TEXTURE_SIZE_MAX  = TEX_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_HEIGHT  = 2'd0,
		REG_TEXTURE_WIDTH  = 2'd1,
		REG_TEXTURE_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [SEL_W-1:0] {
		TEX_X_POS = 2'd0,
		TEX_X_NEG = 2'd1,
		TEX_Y_NEG = 2'd2,
		TEX_Y_POS = 2'd3
	} tex_sel_t;

	typedef struct packed {
		logic [DIST_W-1:0] wall_dist;
		logic [COL_W-1:0]  col;
		tex_sel_t          sel;
	} tc_out_t;

	// Clamp a texture size register to 1..256.
	function automatic logic [TEX_W-1:0] tex_size(input logic [TEX_W-1:0] v);
		logic [TEX_W-1:0] r;
		if (v == '0) begin
			r = TEX_W'(1);
		end else if (v > TEXTURE_SIZE_MAX) begin
			r = TEXTURE_SIZE_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> sv/rcs_div.sv
// ----------------------------------------------------------------------------
// rcs_div
// Pipelined restoring divider, one quotient bit per stage, with saturation
// of the quotient to all ones on a zero divisor or an oversized result.
// ----------------------------------------------------------------------------
module rcs_div #(
	parameter int NW = 27,
	parameter int DW = 24,
	parameter int QW = 16,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);
	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic          v_s    [QW+1];
	logic          sat_s  [QW+1];
	logic [QW-1:0] quo_s  [QW+1];
	logic [SW-1:0] side_s [QW+1];
	logic [NW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			side_s[0] <= side_in;
			// The quotient cannot fit when num >= den * 2^QW.
			sat_s[0]  <= (den == '0) || (CW'(num) >= (CW'(den) << QW));
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic [CW-1:0] shifted;
		logic [CW-1:0] rem_x;
		logic          ge;

		assign shifted = CW'(den_s[k]) << B;
		assign rem_x   = CW'(rem_s[k]);
		assign ge      = rem_x >= shifted;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1]  <= quo_s[k] | (ge ? (QW'(1) << B) : '0);
				sat_s[k+1]  <= sat_s[k];
				side_s[k+1] <= side_s[k];
			end
		end

		if (k < QW - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? NW'(rem_x - shifted) : rem_s[k];
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = sat_s[QW] ? '1 : quo_s[QW];
	assign side_out  = side_s[QW];

endmodule

>>> sv/rcs_texcol.sv
// ----------------------------------------------------------------------------
// rcs_texcol
// Three-stage texture column path: wall hit product with texture selection
// by wall facing, scale by texture width, then mirroring.
// ----------------------------------------------------------------------------
module rcs_texcol #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [rcs_pkg::DIST_W-1:0]  wall_dist,
	input  logic                        hit_side,
	input  logic signed [rcs_pkg::DIR_W-1:0] ray_dir_x,
	input  logic signed [rcs_pkg::DIR_W-1:0] ray_dir_y,
	input  logic [rcs_pkg::POS_W-1:0]   player_x,
	input  logic [rcs_pkg::POS_W-1:0]   player_y,
	input  logic                        step_x_negative,
	input  logic                        step_y_negative,
	input  logic [rcs_pkg::TEX_W-1:0]   tex_width,
	output logic                        out_valid,
	output rcs_pkg::tc_out_t            out_data
);
	import rcs_pkg::*;

	localparam int PW = DIST_W + 1 + DIR_W;
	localparam int EW = PW + FRAC_BITS;

	logic signed [DIR_W-1:0] dir_sel;
	logic signed [PW-1:0]    prod_c;

	logic                 v_s1, v_s2, v_s3;
	logic signed [PW-1:0] prod_s1;
	logic [FRAC_BITS-1:0] base_s1;
	logic                 mirror_s1, mirror_s2;
	tex_sel_t             sel_s1, sel_s2, sel_s3;
	logic [DIST_W-1:0]    dist_s1, dist_s2, dist_s3;
	logic [FRAC_BITS+TEX_W-1:0] scaled_s2;
	logic [COL_W-1:0]     col_s3;

	logic signed [EW-1:0]  prod_ext;
	logic [FRAC_BITS-1:0]  frac;
	logic [COL_W-1:0]      col_raw;
	logic [TEX_W-1:0]      col_mir;

	assign dir_sel = hit_side ? ray_dir_x : ray_dir_y;
	assign prod_c  = $signed({1'b0, wall_dist}) * dir_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1   <= prod_c;
			base_s1   <= hit_side ? player_x[FRAC_BITS-1:0] : player_y[FRAC_BITS-1:0];
			// X-side walls seen with a positive x direction, and y-side walls seen
			// with a negative y direction, are mirrored.
			mirror_s1 <= hit_side ? ray_dir_y[DIR_W-1]
			                      : (!ray_dir_x[DIR_W-1] && (ray_dir_x != '0));
			if (hit_side) begin
				sel_s1 <= step_y_negative ? TEX_Y_NEG : TEX_Y_POS;
			end else begin
				sel_s1 <= step_x_negative ? TEX_X_NEG : TEX_X_POS;
			end
			dist_s1   <= wall_dist;

			scaled_s2 <= (FRAC_BITS+TEX_W)'(frac) * (FRAC_BITS+TEX_W)'(tex_width);
			mirror_s2 <= mirror_s1;
			sel_s2    <= sel_s1;
			dist_s2   <= dist_s1;

			col_s3    <= mirror_s2 ? col_mir[COL_W-1:0] : col_raw;
			sel_s3    <= sel_s2;
			dist_s3   <= dist_s2;
		end
	end

	// Floored product, then only the fraction of the hit point is kept.
	assign prod_ext = EW'(prod_s1);
	assign frac     = base_s1 + FRAC_BITS'(prod_ext >>> FRAC_BITS);

	assign col_raw = scaled_s2[FRAC_BITS+COL_W-1:FRAC_BITS];
	assign col_mir = tex_width - TEX_W'(col_raw) - TEX_W'(1);

	assign out_valid          = v_s3;
	assign out_data.wall_dist = dist_s3;
	assign out_data.col       = col_s3;
	assign out_data.sel       = sel_s3;

endmodule

>>> sv/raycast_column_setup.sv
// ----------------------------------------------------------------------------
// raycast_column_setup
// Per-column wall slice and texture setup for a grid raycaster.
// ----------------------------------------------------------------------------
// One column word is accepted every clock while the output is not stalled,
// and one result word leaves per column, in order. The pipeline depth is
// dominated by the two pipelined restoring dividers (slice height, one
// stage per quotient bit plus a range check, and texel step, likewise).
// A stall on the output freezes the whole pipeline; no words are
// dropped or repeated.
module raycast_column_setup #(
	parameter int FRAC_BITS = rcs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// wall_distance, hit_side, ray_dir_x, ray_dir_y, player_x, player_y,
	// step_x_negative, step_y_negative, zero pad
	input  logic [rcs_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// slice_height, first_pixel, last_pixel, texel_column, texture_select,
	// texel_step, texel_start
	output logic [rcs_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rcs_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rcs_pkg::*;

	localparam int NW1 = SCR_W + FRAC_BITS;
	localparam int NW2 = TEX_W + FRAC_BITS;
	localparam int SB2 = SLICE_W + 2*SCR_W + OFS_W + COL_W + SEL_W;

	logic [SCR_W-1:0] screen_height_q;
	logic [TEX_W-1:0] texture_width_q, texture_height_q;
	logic [SCR_W-1:0] h_eff;
	logic [TEX_W-1:0] tw_eff, th_eff;

	logic    en;
	logic    tc_valid;
	tc_out_t tc_out;

	logic                 d1_valid;
	logic [SLICE_W-1:0]   lh;
	logic [COL_W+SEL_W-1:0] d1_side;

	logic [SCR_W-2:0]   hh;
	logic [SLICE_W-2:0] lh2;
	logic [SLICE_W:0]   sum_c;
	logic [SCR_W-1:0]   first_c, last_c;
	logic [OFS_W-1:0]   ofs_c;

	logic               v_s1;
	logic [SLICE_W-1:0] lh_s1;
	logic [SCR_W-1:0]   first_s1, last_s1;
	logic [OFS_W-1:0]   ofs_s1;
	logic [COL_W-1:0]   col_s1;
	logic [SEL_W-1:0]   sel_s1;

	logic               d2_valid;
	logic [STEP_W-1:0]  step;
	logic [SB2-1:0]     d2_side;
	logic [SLICE_W-1:0] lh_d2;
	logic [SCR_W-1:0]   first_d2, last_d2;
	logic [OFS_W-1:0]   ofs_d2;
	logic [COL_W-1:0]   col_d2;
	logic [SEL_W-1:0]   sel_d2;

	logic                v_s2;
	logic [SLICE_W-1:0]  lh_s2;
	logic [SCR_W-1:0]    first_s2, last_s2;
	logic [COL_W-1:0]    col_s2;
	logic [SEL_W-1:0]    sel_s2;
	logic [STEP_W-1:0]   step_s2;
	logic [START_W-1:0]  start_s2;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q  <= SCREEN_HEIGHT_RST;
			texture_width_q  <= TEXTURE_SIZE_RST;
			texture_height_q <= TEXTURE_SIZE_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCREEN_HEIGHT:  screen_height_q  <= cfg_data;
				REG_TEXTURE_WIDTH:  texture_width_q  <= cfg_data[TEX_W-1:0];
				REG_TEXTURE_HEIGHT: texture_height_q <= cfg_data[TEX_W-1:0];
				default: ;
			endcase
		end
	end

	assign h_eff  = (screen_height_q == '0) ? SCR_W'(1) : screen_height_q;
	assign tw_eff = tex_size(texture_width_q);
	assign th_eff = tex_size(texture_height_q);

	// The pipeline moves as one; it holds only while a result waits.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	rcs_texcol #(.FRAC_BITS(FRAC_BITS)) u_texcol (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (s_tvalid),
		.wall_dist       (s_tdata[23:0]),
		.hit_side        (s_tdata[24]),
		.ray_dir_x       ($signed(s_tdata[45:25])),
		.ray_dir_y       ($signed(s_tdata[66:46])),
		.player_x        (s_tdata[90:67]),
		.player_y        (s_tdata[114:91]),
		.step_x_negative (s_tdata[115]),
		.step_y_negative (s_tdata[116]),
		.tex_width       (tw_eff),
		.out_valid       (tc_valid),
		.out_data        (tc_out)
	);

	rcs_div #(.NW(NW1), .DW(DIST_W), .QW(SLICE_W), .SW(COL_W+SEL_W)) u_div_slice (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (tc_valid),
		.num       (NW1'(h_eff) << FRAC_BITS),
		.den       (tc_out.wall_dist),
		.side_in   ({tc_out.col, tc_out.sel}),
		.out_valid (d1_valid),
		.quo       (lh),
		.side_out  (d1_side)
	);

	// Screen span of the slice, clamped to the screen.
	assign hh    = h_eff[SCR_W-1:1];
	assign lh2   = lh[SLICE_W-1:1];
	assign sum_c = (SLICE_W+1)'(hh) + (SLICE_W+1)'(lh2);

	always_comb begin
		if ((SLICE_W-1)'(hh) >= lh2) begin
			first_c = SCR_W'(hh) - SCR_W'(lh2);
			ofs_c   = '0;
		end else begin
			first_c = '0;
			ofs_c   = OFS_W'(lh2 - (SLICE_W-1)'(hh));
		end
		if (sum_c >= (SLICE_W+1)'(h_eff)) begin
			last_c = h_eff - SCR_W'(1);
		end else begin
			last_c = sum_c[SCR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lh_s1    <= lh;
			first_s1 <= first_c;
			last_s1  <= last_c;
			ofs_s1   <= ofs_c;
			col_s1   <= d1_side[COL_W+SEL_W-1:SEL_W];
			sel_s1   <= d1_side[SEL_W-1:0];
		end
	end

	rcs_div #(.NW(NW2), .DW(SLICE_W), .QW(STEP_W), .SW(SB2)) u_div_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.num       (NW2'(th_eff) << FRAC_BITS),
		.den       (lh_s1),
		.side_in   ({lh_s1, first_s1, last_s1, ofs_s1, col_s1, sel_s1}),
		.out_valid (d2_valid),
		.quo       (step),
		.side_out  (d2_side)
	);

	assign {lh_d2, first_d2, last_d2, ofs_d2, col_d2, sel_d2} = d2_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lh_s2    <= lh_d2;
			first_s2 <= first_d2;
			last_s2  <= last_d2;
			col_s2   <= col_d2;
			sel_s2   <= sel_d2;
			step_s2  <= step;
			start_s2 <= START_W'(ofs_d2) * START_W'(step);
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {start_s2, step_s2, sel_s2, col_s2, last_s2, first_s2, lh_s2};

	a_last_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (last_s2 < h_eff))
		else $error("last pixel beyond the screen");

	a_first_le_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (first_s2 <= last_s2))
		else $error("first pixel after last pixel");

	a_column_in_texture: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (TEX_W'(col_s2) < tw_eff))
		else $error("texel column outside the texture");

	a_zero_slice_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (lh_s2 == '0)) |-> ((step_s2 == '1) && (start_s2 == '0)))
		else $error("zero slice height did not saturate the texel step");

endmodule

>>> tb/raycast_column_setup_test.sv
// ----------------------------------------------------------------------------
// raycast_column_setup_test
// Self-checking bench for the raycaster column setup block. Column words are
// driven with random gaps, results are drawn with random back-pressure, and
// a scoreboard predicts every result word from the register settings.
// ----------------------------------------------------------------------------
module raycast_column_setup_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rcs_pkg::*;

	typedef struct packed {
		logic [23:0] wall_distance;
		logic        hit_side;
		logic [20:0] ray_dir_x;
		logic [20:0] ray_dir_y;
		logic [23:0] player_x;
		logic [23:0] player_y;
		logic        step_x_negative;
		logic        step_y_negative;
	} column_t;

	typedef struct packed {
		logic [15:0] slice_height;
		logic [10:0] first_pixel;
		logic [10:0] last_pixel;
		logic [7:0]  texel_column;
		logic [1:0]  texture_select;
		logic [23:0] texel_step;
		logic [39:0] texel_start;
	} setup_t;

	class column_scoreboard;
		int unsigned screen_h = 480;
		int unsigned tex_w = 64;
		int unsigned tex_h = 64;
		setup_t pending_setups[$];
		int errors = 0;
		int columns = 0;
		int results = 0;

		function void write_reg(cfg_reg_t idx, logic [10:0] value);
			case (idx)
				REG_SCREEN_HEIGHT: screen_h = value;
				REG_TEXTURE_WIDTH: tex_w = value[8:0];
				REG_TEXTURE_HEIGHT: tex_h = value[8:0];
				default: ;
			endcase
		endfunction

		function int unsigned clamp_tex(int unsigned v);
			if (v == 0)
				return 1;
			return (v > 256) ? 256 : v;
		endfunction

		function setup_t compute_setup(column_t c);
			setup_t r;
			longint h, tw, th, lh, first, last, prod, frac, col, stp, offset;
			h = (screen_h == 0) ? 1 : screen_h;
			tw = clamp_tex(tex_w);
			th = clamp_tex(tex_h);
			if (c.wall_distance == 0) begin
				lh = 65535;
			end else begin
				lh = (h << 16) / longint'(c.wall_distance);
				if (lh > 65535)
					lh = 65535;
			end
			first = h / 2 - lh / 2;
			last = h / 2 + lh / 2;
			if (first < 0)
				first = 0;
			if (last >= h)
				last = h - 1;
			// Only bits 31:16 of the product reach the fraction of the hit point.
			if (!c.hit_side)
				prod = longint'(c.wall_distance) * longint'($signed(c.ray_dir_y));
			else
				prod = longint'(c.wall_distance) * longint'($signed(c.ray_dir_x));
			frac = ((c.hit_side ? longint'(c.player_x) : longint'(c.player_y))
				+ (prod >>> 16)) & 64'hFFFF;
			col = (frac * tw) >> 16;
			if ((!c.hit_side && !c.ray_dir_x[20] && c.ray_dir_x != 0) ||
				(c.hit_side && c.ray_dir_y[20]))
				col = tw - col - 1;
			if (!c.hit_side)
				r.texture_select = c.step_x_negative ? TEX_X_NEG : TEX_X_POS;
			else
				r.texture_select = c.step_y_negative ? TEX_Y_NEG : TEX_Y_POS;
			if (lh == 0) begin
				stp = 24'hFFFFFF;
			end else begin
				stp = (th << 16) / lh;
				if (stp > 24'hFFFFFF)
					stp = 24'hFFFFFF;
			end
			offset = first - h / 2 + lh / 2;
			r.slice_height = lh[15:0];
			r.first_pixel = first[10:0];
			r.last_pixel = last[10:0];
			r.texel_column = col[7:0];
			r.texel_step = stp[23:0];
			r.texel_start = 40'(offset * stp);
			return r;
		endfunction

		function void note_column(column_t c);
			pending_setups.push_back(compute_setup(c));
			columns++;
		endfunction

		function void report(string what, longint got, longint want);
			$display("ERROR result %0d: %s got %0d, predicted %0d", results, what, got, want);
			errors++;
		endfunction

		function void check_result(setup_t got);
			setup_t want;
			results++;
			if (pending_setups.size() == 0) begin
				report("unexpected word", 0, 0);
				return;
			end
			want = pending_setups.pop_front();
			if (got.slice_height !== want.slice_height)
				report("slice_height", got.slice_height, want.slice_height);
			if (got.first_pixel !== want.first_pixel)
				report("first_pixel", got.first_pixel, want.first_pixel);
			if (got.last_pixel !== want.last_pixel)
				report("last_pixel", got.last_pixel, want.last_pixel);
			if (got.texel_column !== want.texel_column)
				report("texel_column", got.texel_column, want.texel_column);
			if (got.texture_select !== want.texture_select)
				report("texture_select", got.texture_select, want.texture_select);
			if (got.texel_step !== want.texel_step)
				report("texel_step", got.texel_step, want.texel_step);
			if (got.texel_start !== want.texel_start)
				report("texel_start", got.texel_start, want.texel_start);
		endfunction
	endclass

	localparam int LATENCY = 60;
	localparam int IDLE_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	column_scoreboard board = new();
	bit no_gaps = 0;
	bit hold_done = 0;
	int idle_cycles = 0;

	raycast_column_setup dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (no_gaps || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_column(column_t c);
		return {3'b000, c.step_y_negative, c.step_x_negative, c.player_y, c.player_x,
			c.ray_dir_y, c.ray_dir_x, c.hit_side, c.wall_distance};
	endfunction

	function automatic setup_t unpack_setup(logic [OUT_DATA_W-1:0] d);
		setup_t r;
		r.slice_height = d[15:0];
		r.first_pixel = d[26:16];
		r.last_pixel = d[37:27];
		r.texel_column = d[45:38];
		r.texture_select = d[47:46];
		r.texel_step = d[71:48];
		r.texel_start = d[111:72];
		return r;
	endfunction

	function automatic column_t unpack_column(logic [IN_DATA_W-1:0] d);
		column_t c;
		c.wall_distance = d[23:0];
		c.hit_side = d[24];
		c.ray_dir_x = d[45:25];
		c.ray_dir_y = d[66:46];
		c.player_x = d[90:67];
		c.player_y = d[114:91];
		c.step_x_negative = d[115];
		c.step_y_negative = d[116];
		return c;
	endfunction

	// Accepted words are recorded at the rising edge, from sampled values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_column(unpack_column(s_tdata));
			if (m_tvalid && m_tready)
				board.check_result(unpack_setup(m_tdata));
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_reg_t'(cfg_index), cfg_data);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
				$display("raycast_column_setup: mismatch");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold once traffic is flowing.
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && board.columns > 300) begin
				hold_done = 1;
				m_tready = 0;
				for (n = 0; n < 400; n++)
					@(negedge clk);
			end
			n = gap_len();
			if (n == 0) begin
				m_tready = 1;
			end else begin
				m_tready = 0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic send_column(column_t c);
		repeat (gap_len()) @(negedge clk);
		s_tvalid = 1;
		s_tdata = pack_column(c);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic write_register(cfg_reg_t idx, logic [10:0] value);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		while (board.pending_setups.size() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	function automatic column_t random_column();
		column_t c;
		int scale;
		scale = $urandom_range(24, 1);
		c.wall_distance = 24'($urandom & ((1 << scale) - 1));
		if ($urandom_range(3) == 0)
			c.wall_distance = 24'($urandom_range(24'h0C0000, 24'h002000));
		c.hit_side = 1'($urandom);
		c.ray_dir_x = 21'($urandom);
		c.ray_dir_y = 21'($urandom);
		if ($urandom_range(7) == 0)
			c.ray_dir_x = 0;
		if ($urandom_range(7) == 0)
			c.ray_dir_y = 0;
		c.player_x = 24'($urandom);
		c.player_y = 24'($urandom);
		c.step_x_negative = 1'($urandom);
		c.step_y_negative = 1'($urandom);
		return c;
	endfunction

	task automatic directed_columns();
		column_t c;
		int i;
		for (i = 0; i < 16; i++) begin
			c = random_column();
			case (i % 8)
				0: c.wall_distance = 0;
				1: c.wall_distance = 1;
				2: c.wall_distance = 24'hFFFFFF;
				3: c.wall_distance = 24'h010000;
				4: c.wall_distance = 24'h000100;
				default: ;
			endcase
			c.hit_side = i[0];
			c.step_x_negative = i[1];
			c.step_y_negative = i[2];
			c.ray_dir_x = (i < 8) ? 21'h100000 : 21'h0FFFFF;
			c.ray_dir_y = (i[3] ^ i[0]) ? 21'h100000 : 21'h0FFFFF;
			if (i == 5)
				c.ray_dir_x = 0;
			if (i == 6)
				c.ray_dir_y = 0;
			c.player_x = i[1] ? 24'hFFFFFF : 24'h0;
			c.player_y = i[2] ? 24'h0 : 24'hFFFFFF;
			send_column(c);
		end
	endtask

	initial begin
		logic [10:0] settings [6][3];
		int p, k;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = REG_SCREEN_HEIGHT;
		cfg_data = '0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		settings[0] = '{11'd480, 11'd64, 11'd64};
		settings[1] = '{11'd1, 11'd1, 11'd1};
		settings[2] = '{11'd2047, 11'd256, 11'd256};
		// Zero screen height and out-of-range texture sizes are clamped.
		settings[3] = '{11'd0, 11'd0, 11'd300};
		settings[4] = '{11'd720, 11'd2047, 11'd0};
		settings[5] = '{11'd200, 11'd37, 11'd129};

		for (p = 0; p < 6; p++) begin
			if (p > 0) begin
				drain();
				write_register(REG_SCREEN_HEIGHT, settings[p][0]);
				write_register(REG_TEXTURE_WIDTH, settings[p][1]);
				write_register(REG_TEXTURE_HEIGHT, settings[p][2]);
			end
			no_gaps = (p == 2);
			if (p == 0)
				directed_columns();
			for (k = 0; k < 300; k++) begin
				send_column(random_column());
				if (k == 150 && p == 4)
					drain();
			end
		end
		drain();
		for (k = 0; k < 3; k++)
			write_register(cfg_reg_t'(k), 11'($urandom));
		for (k = 0; k < 30; k++)
			send_column(random_column());

		drain();
		$display("Covered %0d columns and %0d results over seven register settings,",
			board.columns, board.results);
		$display("including zero and saturating distances and clamped register values.");
		if (board.errors == 0 && board.pending_setups.size() == 0) begin
			$display("raycast_column_setup: match");
		end else begin
			$display("raycast_column_setup: mismatch");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/rcs_pkg.sv
sv/rcs_div.sv
sv/rcs_texcol.sv
sv/raycast_column_setup.sv
tb/raycast_column_setup_test.sv
